// File: rtl/core/look_at_rotation_matrix_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the look-at rotation block
// Both expect clk and rst_n in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef LOOK_AT_ROTATION_MATRIX_MACROS_SVH
`define LOOK_AT_ROTATION_MATRIX_MACROS_SVH

// same-cycle implication, disabled in reset
`define LAR_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, disabled in reset
`define LAR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/core/lar_pkg.sv
// ---------------------------------------------------------------------------
// lar_pkg
// Shared widths, status codes and rounding helpers for the look-at block.
// ---------------------------------------------------------------------------
package lar_pkg;

  localparam int COORD_W = 32;
  localparam int MAG_W   = 32;
  localparam int SUM_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int DEN_W   = ROOT_W + 1;
  localparam int QUO_W   = 32;
  localparam int NUM_W   = DEN_W - 1 + QUO_W;
  localparam int OUT_W   = 16;
  localparam int Q14_ONE = 16384;

  typedef enum logic [1:0] {
    DEG_NONE        = 2'd0,
    DEG_SAME_POINT  = 2'd1,
    DEG_PARALLEL_UP = 2'd2
  } deg_t;

  typedef logic signed [OUT_W-1:0] q14_t;

  // Q2.30 -> Q1.14, round half away from zero, clamp to +-1.0
  function automatic q14_t q30_to_q14(input logic signed [31:0] v);
    logic [31:0] mag;
    logic [16:0] q;
    logic [15:0] qm;
    mag = v[31] ? 32'(-v) : 32'(v);
    q   = 17'(({1'b0, mag} + 33'd32768) >> 16);
    if (q > 17'(Q14_ONE)) q = 17'(Q14_ONE);
    qm = {1'b0, q[14:0]};
    return v[31] ? q14_t'(-qm) : q14_t'(qm);
  endfunction

  // Q4.60 -> Q1.14, round half away from zero, clamp to +-1.0
  function automatic q14_t q60_to_q14(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [17:0] q;
    logic [15:0] qm;
    mag = v[63] ? 64'(-v) : 64'(v);
    q   = 18'(({1'b0, mag} + {19'd0, 1'b1, 45'd0}) >> 46);
    if (q > 18'(Q14_ONE)) q = 18'(Q14_ONE);
    qm = {1'b0, q[14:0]};
    return v[63] ? q14_t'(-qm) : q14_t'(qm);
  endfunction

endpackage

// File: rtl/core/lar_if.sv
// ---------------------------------------------------------------------------
// lar_in_if / lar_out_if
// Valid/ready channels for the look-at block requests and results.
// ---------------------------------------------------------------------------
interface lar_in_if;
  logic                      valid;
  logic                      ready;
  logic signed [31:0]        eye_x;
  logic signed [31:0]        eye_y;
  logic signed [31:0]        eye_z;
  logic signed [31:0]        center_x;
  logic signed [31:0]        center_y;
  logic signed [31:0]        center_z;

  modport source (output valid, eye_x, eye_y, eye_z, center_x, center_y, center_z,
                  input ready);
  modport sink   (input valid, eye_x, eye_y, eye_z, center_x, center_y, center_z,
                  output ready);
endinterface

interface lar_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic signed [15:0] right_z;
  logic signed [15:0] forward_x;
  logic signed [15:0] forward_y;
  logic signed [15:0] forward_z;
  logic signed [15:0] down_x;
  logic signed [15:0] down_y;
  logic signed [15:0] down_z;
  logic [1:0]         degenerate;

  modport source (output valid, right_x, right_y, right_z, forward_x, forward_y,
                  forward_z, down_x, down_y, down_z, degenerate, input ready);
  modport sink   (input valid, right_x, right_y, right_z, forward_x, forward_y,
                  forward_z, down_x, down_y, down_z, degenerate, output ready);
endinterface

// File: rtl/core/lar_isqrt.sv
// ---------------------------------------------------------------------------
// lar_isqrt
// Pipelined integer square root, one root bit per stage, several lanes.
// ---------------------------------------------------------------------------
module lar_isqrt #(
  parameter int LANES  = 2,
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [lar_pkg::SUM_W-1:0]   in_rad [LANES],
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic [lar_pkg::ROOT_W-1:0]  out_root [LANES],
  output logic [SIDE_W-1:0]           out_side
);

  localparam int RAD_W = lar_pkg::SUM_W;
  localparam int RT_W  = lar_pkg::ROOT_W;
  localparam int REM_W = RT_W + 1;
  localparam int STEPS = RT_W;

  logic [RAD_W-1:0]  rad_r  [STEPS][LANES];
  logic [REM_W-1:0]  rem_r  [STEPS][LANES];
  logic [RT_W-1:0]   root_r [STEPS][LANES];
  logic [SIDE_W-1:0] side_r [STEPS];
  logic [STEPS-1:0]  vld_r;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [RAD_W-1:0]  rad_in  [LANES];
    logic [REM_W-1:0]  rem_in  [LANES];
    logic [RT_W-1:0]   root_in [LANES];
    logic [RAD_W-1:0]  rad_nxt  [LANES];
    logic [REM_W-1:0]  rem_nxt  [LANES];
    logic [RT_W-1:0]   root_nxt [LANES];
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;

    if (k == 0) begin : g_first
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign side_in = side_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [REM_W+1:0] rem_sh;
      logic [REM_W+1:0] trial;
      logic             ge;

      if (k == 0) begin : g_first
        assign rad_in[l]  = in_rad[l];
        assign rem_in[l]  = '0;
        assign root_in[l] = '0;
      end else begin : g_next
        assign rad_in[l]  = rad_r[k-1][l];
        assign rem_in[l]  = rem_r[k-1][l];
        assign root_in[l] = root_r[k-1][l];
      end

      // bring down two radicand bits, try (root << 2) | 1
      assign rem_sh = {rem_in[l], rad_in[l][RAD_W-1 -: 2]};
      assign trial  = {1'b0, root_in[l], 2'b01};
      assign ge     = (rem_sh >= trial);

      assign rem_nxt[l]  = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      assign root_nxt[l] = {root_in[l][RT_W-2:0], ge};
      assign rad_nxt[l]  = {rad_in[l][RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_in;
        rad_r[k]  <= rad_nxt;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
      end
    end
  end

  assign out_valid = vld_r[STEPS-1];
  assign out_root  = root_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule

// File: rtl/core/lar_udiv.sv
// ---------------------------------------------------------------------------
// lar_udiv
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// The upper half of the numerator must be below the divisor.
// ---------------------------------------------------------------------------
module lar_udiv #(
  parameter int LANES  = 5,
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [lar_pkg::NUM_W-1:0]  in_num [LANES],
  input  logic [lar_pkg::DEN_W-1:0]  in_den [LANES],
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [lar_pkg::QUO_W-1:0]  out_quo [LANES],
  output logic [SIDE_W-1:0]          out_side
);

  localparam int D_W   = lar_pkg::DEN_W;
  localparam int Q_W   = lar_pkg::QUO_W;
  localparam int N_W   = lar_pkg::NUM_W;
  localparam int STEPS = Q_W;

  logic [D_W-1:0]    rem_r [STEPS][LANES];
  logic [Q_W-1:0]    lo_r  [STEPS][LANES];
  logic [Q_W-1:0]    quo_r [STEPS][LANES];
  logic [D_W-1:0]    den_r [STEPS][LANES];
  logic [SIDE_W-1:0] side_r [STEPS];
  logic [STEPS-1:0]  vld_r;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [D_W-1:0]    rem_in  [LANES];
    logic [Q_W-1:0]    lo_in   [LANES];
    logic [Q_W-1:0]    quo_in  [LANES];
    logic [D_W-1:0]    den_in  [LANES];
    logic [D_W-1:0]    rem_nxt [LANES];
    logic [Q_W-1:0]    lo_nxt  [LANES];
    logic [Q_W-1:0]    quo_nxt [LANES];
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;

    if (k == 0) begin : g_first
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign side_in = side_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [D_W:0] rs;
      logic         ge;

      if (k == 0) begin : g_first
        assign rem_in[l] = D_W'(in_num[l][N_W-1:Q_W]);
        assign lo_in[l]  = in_num[l][Q_W-1:0];
        assign quo_in[l] = '0;
        assign den_in[l] = in_den[l];
      end else begin : g_next
        assign rem_in[l] = rem_r[k-1][l];
        assign lo_in[l]  = lo_r[k-1][l];
        assign quo_in[l] = quo_r[k-1][l];
        assign den_in[l] = den_r[k-1][l];
      end

      assign rs         = {rem_in[l], lo_in[l][Q_W-1]};
      assign ge         = (rs >= {1'b0, den_in[l]});
      assign rem_nxt[l] = ge ? D_W'(rs - {1'b0, den_in[l]}) : D_W'(rs);
      assign lo_nxt[l]  = {lo_in[l][Q_W-2:0], 1'b0};
      assign quo_nxt[l] = {quo_in[l][Q_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_in;
        rem_r[k]  <= rem_nxt;
        lo_r[k]   <= lo_nxt;
        quo_r[k]  <= quo_nxt;
        den_r[k]  <= den_in;
      end
    end
  end

  assign out_valid = vld_r[STEPS-1];
  assign out_quo   = quo_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule

// File: rtl/core/look_at_rotation_matrix.sv
// Path: stages 1-5, root pipeline, stage 6, divider pipeline, stages 7-10, then out_ch.
// Throughput: one request per cycle unless out_ch stalls; the 32-stage root and
//   32-stage divider pipelines set the depth, each retiring one bit per stage.
// A stalled result register freezes the whole pipeline; nothing is dropped.
// Reset (rst_n low, synchronous) clears every stage valid bit.
// ---------------------------------------------------------------------------
// look_at_rotation_matrix
// Rotation part of a look-at view matrix with up = (0,1,0), Q16.16 in,
// Q1.14 right / forward / down columns out, plus a degenerate status.
// ---------------------------------------------------------------------------
module look_at_rotation_matrix (
  input  logic         clk,
  input  logic         rst_n,
  lar_in_if.sink       in_ch,
  lar_out_if.source    out_ch
);

  localparam int MW     = lar_pkg::MAG_W;
  localparam int SW     = lar_pkg::SUM_W;
  localparam int RW     = lar_pkg::ROOT_W;
  localparam int DW     = lar_pkg::DEN_W;
  localparam int QW     = lar_pkg::QUO_W;
  localparam int NW     = lar_pkg::NUM_W;
  localparam int SQ_SIDE  = 5 * MW + 3 + 2;
  localparam int DIV_SIDE = 3 + 2;

  function automatic logic [4:0] msb_pos(input logic [MW-1:0] m);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < MW; i++) begin
      if (m[i]) p = 5'(i);
    end
    return p;
  endfunction

  // largest magnitude lands in [2^30, 2^31]
  function automatic logic [MW-1:0] prescale(input logic [MW-1:0] m, input logic [4:0] pos,
                                             input logic big, input logic zero);
    logic [MW-1:0] r;
    if (zero) begin
      r = m;
    end else if (big) begin
      r = MW'(({1'b0, m} + 33'd1) >> 1);
    end else begin
      r = m << (5'd30 - pos);
    end
    return r;
  endfunction

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r;

  assign adv         = !v10_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ---- stage 1: difference and magnitudes
  logic signed [32:0] dx, dy, dz;
  logic [MW-1:0]      mag_nxt [3];
  logic [MW-1:0]      mag1_r  [3];
  logic [2:0]         neg1_r;
  lar_pkg::deg_t      st_nxt, st1_r;

  assign dx = {in_ch.center_x[31], in_ch.center_x} - {in_ch.eye_x[31], in_ch.eye_x};
  assign dy = {in_ch.center_y[31], in_ch.center_y} - {in_ch.eye_y[31], in_ch.eye_y};
  assign dz = {in_ch.center_z[31], in_ch.center_z} - {in_ch.eye_z[31], in_ch.eye_z};

  always_comb begin
    mag_nxt[0] = dx[32] ? MW'(-dx) : dx[MW-1:0];
    mag_nxt[1] = dy[32] ? MW'(-dy) : dy[MW-1:0];
    mag_nxt[2] = dz[32] ? MW'(-dz) : dz[MW-1:0];
    if (mag_nxt[0] == '0 && mag_nxt[1] == '0 && mag_nxt[2] == '0) begin
      st_nxt = lar_pkg::DEG_SAME_POINT;
    end else if (mag_nxt[0] == '0 && mag_nxt[2] == '0) begin
      st_nxt = lar_pkg::DEG_PARALLEL_UP;
    end else begin
      st_nxt = lar_pkg::DEG_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag1_r <= mag_nxt;
      neg1_r <= {dz[32], dy[32], dx[32]};
      st1_r  <= st_nxt;
    end
  end

  // ---- stage 2: normalizing shift amounts
  logic [MW-1:0] mxf, mxh;
  logic [MW-1:0] mag2_r [3];
  logic [2:0]    neg2_r;
  lar_pkg::deg_t st2_r;
  logic [4:0]    posf_r, posh_r;
  logic          bigf_r, zf_r, bigh_r, zh_r;

  always_comb begin
    mxh = (mag1_r[0] > mag1_r[2]) ? mag1_r[0] : mag1_r[2];
    mxf = (mxh > mag1_r[1]) ? mxh : mag1_r[1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag2_r <= mag1_r;
      neg2_r <= neg1_r;
      st2_r  <= st1_r;
      posf_r <= msb_pos(mxf);
      posh_r <= msb_pos(mxh);
      bigf_r <= mxf[MW-1];
      bigh_r <= mxh[MW-1];
      zf_r   <= (mxf == '0);
      zh_r   <= (mxh == '0);
    end
  end

  // ---- stage 3: apply prescale; right vector magnitudes are (|dx|, |dz|)
  logic [MW-1:0] fm3_r [3];
  logic [MW-1:0] hm3_r [2];
  logic [2:0]    neg3_r;
  lar_pkg::deg_t st3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        fm3_r[i] <= prescale(mag2_r[i], posf_r, bigf_r, zf_r);
      end
      hm3_r[0] <= prescale(mag2_r[0], posh_r, bigh_r, zh_r);
      hm3_r[1] <= prescale(mag2_r[2], posh_r, bigh_r, zh_r);
      neg3_r   <= neg2_r;
      st3_r    <= st2_r;
    end
  end

  // ---- stage 4: squares
  logic [SW-1:0] sqf4_r [3];
  logic [SW-1:0] sqh4_r [2];
  logic [MW-1:0] fm4_r [3];
  logic [MW-1:0] hm4_r [2];
  logic [2:0]    neg4_r;
  lar_pkg::deg_t st4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sqf4_r[i] <= SW'(fm3_r[i]) * SW'(fm3_r[i]);
      end
      for (int i = 0; i < 2; i++) begin
        sqh4_r[i] <= SW'(hm3_r[i]) * SW'(hm3_r[i]);
      end
      fm4_r  <= fm3_r;
      hm4_r  <= hm3_r;
      neg4_r <= neg3_r;
      st4_r  <= st3_r;
    end
  end

  // ---- stage 5: sums of squares
  logic [SW-1:0]      rad5_r [2];
  logic [SQ_SIDE-1:0] side5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      rad5_r[0] <= sqf4_r[0] + sqf4_r[1] + sqf4_r[2];
      rad5_r[1] <= sqh4_r[0] + sqh4_r[1];
      side5_r   <= {fm4_r[0], fm4_r[1], fm4_r[2], hm4_r[0], hm4_r[1], neg4_r, st4_r};
    end
  end

  // ---- square roots
  logic               sq_valid;
  logic [RW-1:0]      sq_root [2];
  logic [SQ_SIDE-1:0] sq_side;

  lar_isqrt #(
    .LANES  (2),
    .SIDE_W (SQ_SIDE)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v5_r),
    .in_rad    (rad5_r),
    .in_side   (side5_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // ---- stage 6: numerators (mag * 2^31 + r) and divisors (2r)
  logic [MW-1:0]       sfm [3];
  logic [MW-1:0]       shm [2];
  logic [2:0]          sneg;
  logic [1:0]          sst;
  logic [MW-1:0]       lane_mag [5];
  logic [RW-1:0]       lane_root [5];
  logic [NW-1:0]       num6_r [5];
  logic [DW-1:0]       den6_r [5];
  logic [DIV_SIDE-1:0] side6_r;

  assign {sfm[0], sfm[1], sfm[2], shm[0], shm[1], sneg, sst} = sq_side;

  // lanes: forward x/y/z, right x (from |dz|), right z (from |dx|)
  always_comb begin
    lane_mag[0]  = sfm[0];
    lane_mag[1]  = sfm[1];
    lane_mag[2]  = sfm[2];
    lane_mag[3]  = shm[1];
    lane_mag[4]  = shm[0];
    lane_root[0] = sq_root[0];
    lane_root[1] = sq_root[0];
    lane_root[2] = sq_root[0];
    lane_root[3] = sq_root[1];
    lane_root[4] = sq_root[1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 5; i++) begin
        num6_r[i] <= (NW'(lane_mag[i]) << 31) + NW'(lane_root[i]);
        den6_r[i] <= {lane_root[i], 1'b0};
      end
      side6_r <= {sneg, sst};
    end
  end

  // ---- unit components
  logic                dv_valid;
  logic [QW-1:0]       dv_quo [5];
  logic [DIV_SIDE-1:0] dv_side;

  lar_udiv #(
    .LANES  (5),
    .SIDE_W (DIV_SIDE)
  ) u_udiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v6_r),
    .in_num    (num6_r),
    .in_den    (den6_r),
    .in_side   (side6_r),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // ---- stage 7: signs and degenerate masking
  logic [2:0]         dneg;
  lar_pkg::deg_t      dst;
  logic signed [31:0] g7_r [3];
  logic signed [31:0] px7_r, pz7_r;
  lar_pkg::deg_t      st7_r;

  assign dneg = dv_side[4:2];
  assign dst  = lar_pkg::deg_t'(dv_side[1:0]);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (dst == lar_pkg::DEG_SAME_POINT) begin
          g7_r[i] <= '0;
        end else begin
          g7_r[i] <= dneg[i] ? -$signed(dv_quo[i]) : $signed(dv_quo[i]);
        end
      end
      if (dst != lar_pkg::DEG_NONE) begin
        px7_r <= '0;
        pz7_r <= '0;
      end else begin
        px7_r <= dneg[2] ? -$signed(dv_quo[3]) : $signed(dv_quo[3]);
        pz7_r <= dneg[0] ? $signed(dv_quo[4]) : -$signed(dv_quo[4]);
      end
      st7_r <= dst;
    end
  end

  // ---- stage 8: cross-product terms, Q1.14 of first two columns
  logic signed [63:0] pr8_r [4];
  lar_pkg::q14_t      fw8_r [3];
  lar_pkg::q14_t      rx8_r, rz8_r;
  lar_pkg::deg_t      st8_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pr8_r[0] <= 64'(pz7_r) * 64'(g7_r[1]);
      pr8_r[1] <= 64'(g7_r[0]) * 64'(pz7_r);
      pr8_r[2] <= 64'(g7_r[2]) * 64'(px7_r);
      pr8_r[3] <= 64'(px7_r) * 64'(g7_r[1]);
      for (int i = 0; i < 3; i++) begin
        fw8_r[i] <= lar_pkg::q30_to_q14(g7_r[i]);
      end
      rx8_r <= lar_pkg::q30_to_q14(px7_r);
      rz8_r <= lar_pkg::q30_to_q14(pz7_r);
      st8_r <= st7_r;
    end
  end

  // ---- stage 9: down = -(forward x right)
  logic signed [63:0] dn9_r [3];
  lar_pkg::q14_t      fw9_r [3];
  lar_pkg::q14_t      rx9_r, rz9_r;
  lar_pkg::deg_t      st9_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dn9_r[0] <= -pr8_r[0];
      dn9_r[1] <= pr8_r[1] - pr8_r[2];
      dn9_r[2] <= pr8_r[3];
      fw9_r    <= fw8_r;
      rx9_r    <= rx8_r;
      rz9_r    <= rz8_r;
      st9_r    <= st8_r;
    end
  end

  // ---- stage 10: result register
  lar_pkg::q14_t dn10_r [3];
  lar_pkg::q14_t fw10_r [3];
  lar_pkg::q14_t rx10_r, rz10_r;
  lar_pkg::deg_t st10_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dn10_r[i] <= lar_pkg::q60_to_q14(dn9_r[i]);
      end
      fw10_r <= fw9_r;
      rx10_r <= rx9_r;
      rz10_r <= rz9_r;
      st10_r <= st9_r;
    end
  end

  // ---- valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
    end else if (adv) begin
      v1_r  <= in_ch.valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      v6_r  <= sq_valid;
      v7_r  <= dv_valid;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
    end
  end

  assign out_ch.valid      = v10_r;
  assign out_ch.right_x    = rx10_r;
  assign out_ch.right_y    = '0;
  assign out_ch.right_z    = rz10_r;
  assign out_ch.forward_x  = fw10_r[0];
  assign out_ch.forward_y  = fw10_r[1];
  assign out_ch.forward_z  = fw10_r[2];
  assign out_ch.down_x     = dn10_r[0];
  assign out_ch.down_y     = dn10_r[1];
  assign out_ch.down_z     = dn10_r[2];
  assign out_ch.degenerate = st10_r;

endmodule

// File: rtl/core/lar_checker.sv
// ---------------------------------------------------------------------------
// lar_checker
// Port-level checks on the look-at block results.
// ---------------------------------------------------------------------------
`include "look_at_rotation_matrix_macros.svh"

module lar_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] right_x,
  input logic signed [15:0] right_z,
  input logic signed [15:0] forward_x,
  input logic signed [15:0] forward_y,
  input logic signed [15:0] forward_z,
  input logic signed [15:0] down_x,
  input logic signed [15:0] down_y,
  input logic signed [15:0] down_z,
  input logic [1:0]         degenerate
);

  logic same_pt, parallel, any_deg, side_zero;

  assign same_pt   = out_valid && (degenerate == lar_pkg::DEG_SAME_POINT);
  assign parallel  = out_valid && (degenerate == lar_pkg::DEG_PARALLEL_UP);
  assign any_deg   = out_valid && (degenerate != lar_pkg::DEG_NONE);
  assign side_zero = (right_x == 16'sd0) && (right_z == 16'sd0) && (down_x == 16'sd0)
                     && (down_y == 16'sd0) && (down_z == 16'sd0);

  `LAR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped under stall")
  `LAR_ASSERT_IMPL(a_deg_zero, any_deg, side_zero, "degenerate result has nonzero right/down")
  `LAR_ASSERT_IMPL(a_same_fwd, same_pt, forward_x == 16'sd0 && forward_y == 16'sd0 && forward_z == 16'sd0, "eye at target but forward nonzero")
  `LAR_ASSERT_IMPL(a_par_fwd, parallel, forward_x == 16'sd0 && forward_z == 16'sd0 && (forward_y == 16'sd16384 || forward_y == -16'sd16384), "vertical view not unit y")

endmodule

bind look_at_rotation_matrix lar_checker u_lar_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .right_x    (out_ch.right_x),
  .right_z    (out_ch.right_z),
  .forward_x  (out_ch.forward_x),
  .forward_y  (out_ch.forward_y),
  .forward_z  (out_ch.forward_z),
  .down_x     (out_ch.down_x),
  .down_y     (out_ch.down_y),
  .down_z     (out_ch.down_z),
  .degenerate (out_ch.degenerate)
);

// File: test/look_at_rotation_matrix_tb.sv
// ---------------------------------------------------------------------------
// look_at_rotation_matrix_tb
// Drives eye/target requests through the look-at block and checks every
// result against an in-bench fixed-point model of the rotation columns.
// ---------------------------------------------------------------------------
module look_at_rotation_matrix_tb;

  typedef struct {
    logic signed [31:0] ex, ey, ez, cx, cy, cz;
  } view_req_t;

  typedef struct packed {
    logic [15:0] rx, ry, rz, fx, fy, fz, dx, dy, dz;
    logic [1:0]  deg;
  } basis_t;

  logic clk;
  logic rst_n;
  int   cyc;

  lar_in_if  in_ch();
  lar_out_if out_ch();

  look_at_rotation_matrix u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  view_req_t pending_reqs[$];
  basis_t    expected_basis[$];
  int        mismatches;
  int        stray_results;
  bit        stim_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // ---- fixed-point model --------------------------------------------------
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bit_w;
    res   = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v   = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // bring largest magnitude into [2^30, 2^31]
  function automatic void norm_range(inout logic [63:0] a, inout logic [63:0] b,
                                     inout logic [63:0] c);
    logic [63:0] mx;
    mx = a;
    if (b > mx) mx = b;
    if (c > mx) mx = c;
    if (mx == 0) return;
    if (mx >= (64'd1 << 31)) begin
      a = (a + 1) >> 1;
      b = (b + 1) >> 1;
      c = (c + 1) >> 1;
      return;
    end
    while (mx < (64'd1 << 30)) begin
      mx = mx << 1;
      a  = a << 1;
      b  = b << 1;
      c  = c << 1;
    end
  endfunction

  function automatic longint unit_comp(input logic [63:0] m, input bit ng,
                                       input logic [63:0] r);
    logic [63:0] q;
    if (r == 0) return 0;
    q = ((m << 31) + r) / (r << 1);
    return ng ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] round_q14(input longint v, input int sh);
    logic [63:0] m, q;
    longint      s;
    m = (v < 0) ? 64'(-v) : 64'(v);
    q = (m + (64'd1 << (sh - 1))) >> sh;
    if (q > 64'(lar_pkg::Q14_ONE)) q = 64'(lar_pkg::Q14_ONE);
    s = (v < 0) ? -longint'(q) : longint'(q);
    return s[15:0];
  endfunction

  function automatic basis_t look_at_basis(input view_req_t rq);
    basis_t         b;
    longint         d[3];
    logic [63:0]    mg[3], f0, f1, f2, h0, h1, h2, r, rh;
    bit             ng[3];
    longint         g[3];
    longint         px, pz;
    lar_pkg::deg_t  st;
    d[0] = longint'(rq.cx) - longint'(rq.ex);
    d[1] = longint'(rq.cy) - longint'(rq.ey);
    d[2] = longint'(rq.cz) - longint'(rq.ez);
    for (int i = 0; i < 3; i++) begin
      ng[i] = d[i] < 0;
      mg[i] = ng[i] ? 64'(-d[i]) : 64'(d[i]);
      g[i]  = 0;
    end
    px = 0;
    pz = 0;
    st = lar_pkg::DEG_NONE;
    if (mg[0] == 0 && mg[1] == 0 && mg[2] == 0) begin
      st = lar_pkg::DEG_SAME_POINT;
    end else begin
      f0 = mg[0]; f1 = mg[1]; f2 = mg[2];
      norm_range(f0, f1, f2);
      r = int_sqrt(f0 * f0 + f1 * f1 + f2 * f2);
      g[0] = unit_comp(f0, ng[0], r);
      g[1] = unit_comp(f1, ng[1], r);
      g[2] = unit_comp(f2, ng[2], r);
      if (mg[0] == 0 && mg[2] == 0) begin
        st = lar_pkg::DEG_PARALLEL_UP;
      end else begin
        h0 = mg[0]; h1 = mg[2]; h2 = 0;
        norm_range(h0, h1, h2);
        rh = int_sqrt(h0 * h0 + h1 * h1);
        px = unit_comp(h1, ng[2], rh);
        pz = unit_comp(h0, !ng[0], rh);
      end
    end
    b.rx  = round_q14(px, 16);
    b.ry  = 16'd0;
    b.rz  = round_q14(pz, 16);
    b.fx  = round_q14(g[0], 16);
    b.fy  = round_q14(g[1], 16);
    b.fz  = round_q14(g[2], 16);
    b.dx  = round_q14(-pz * g[1], 46);
    b.dy  = round_q14(g[0] * pz - g[2] * px, 46);
    b.dz  = round_q14(px * g[1], 46);
    b.deg = st;
    return b;
  endfunction

  // ---- idle pattern: none inside a quiet window ---------------------------
  function automatic bit idle_now();
    if (cyc >= 350 && cyc < 500) return 1'b0;
    return $urandom_range(99) < 9;
  endfunction

  // ---- driver -------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_basis.push_back(look_at_basis('{in_ch.eye_x, in_ch.eye_y,
          in_ch.eye_z, in_ch.center_x, in_ch.center_y, in_ch.center_z}));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_reqs.size() != 0 && !idle_now()) begin
          view_req_t rq;
          rq = pending_reqs.pop_front();
          in_ch.eye_x    <= rq.ex;
          in_ch.eye_y    <= rq.ey;
          in_ch.eye_z    <= rq.ez;
          in_ch.center_x <= rq.cx;
          in_ch.center_y <= rq.cy;
          in_ch.center_z <= rq.cz;
          in_ch.valid    <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---- receiver, with one long hold-off -----------------------------------
  int hold_cnt;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_cnt     <= 0;
    end else if (cyc == 100) begin
      hold_cnt     <= 200;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt     <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !idle_now();
    end
  end

  // ---- monitor ------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_basis.size() == 0) begin
        stray_results++;
        $display("unexpected result at cycle %0d", cyc);
      end else begin
        basis_t e, a;
        e = expected_basis.pop_front();
        a.rx = out_ch.right_x;   a.ry = out_ch.right_y;   a.rz = out_ch.right_z;
        a.fx = out_ch.forward_x; a.fy = out_ch.forward_y; a.fz = out_ch.forward_z;
        a.dx = out_ch.down_x;    a.dy = out_ch.down_y;    a.dz = out_ch.down_z;
        a.deg = out_ch.degenerate;
        if (a != e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch cyc %0d exp r=%h %h %h f=%h %h %h d=%h %h %h s=%0d got r=%h %h %h f=%h %h %h d=%h %h %h s=%0d",
                     cyc, e.rx, e.ry, e.rz, e.fx, e.fy, e.fz, e.dx, e.dy, e.dz, e.deg,
                     a.rx, a.ry, a.rz, a.fx, a.fy, a.fz, a.dx, a.dy, a.dz, a.deg);
        end
      end
    end
  end

  // ---- stimulus -----------------------------------------------------------
  function automatic view_req_t mk(input logic [31:0] ex, ey, ez, cx, cy, cz);
    view_req_t rq;
    rq.ex = ex; rq.ey = ey; rq.ez = ez; rq.cx = cx; rq.cy = cy; rq.cz = cz;
    return rq;
  endfunction

  function automatic logic [31:0] rnd32();
    return $urandom;
  endfunction

  function automatic logic [31:0] near(input logic [31:0] base);
    return base + 32'($signed($urandom_range(64)) - 32);
  endfunction

  initial begin
    logic [31:0] MN, MX, ex, ey, ez;
    MN = 32'h8000_0000;
    MX = 32'h7fff_ffff;
    cyc = 0;
    mismatches = 0;
    stray_results = 0;
    stim_done = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.eye_x = 0; in_ch.eye_y = 0; in_ch.eye_z = 0;
    in_ch.center_x = 0; in_ch.center_y = 0; in_ch.center_z = 0;
    out_ch.ready = 1'b0;

    // eye on target
    pending_reqs.push_back(mk(0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(MN, MX, MN, MN, MX, MN));
    // looking straight up / down
    pending_reqs.push_back(mk(0, 0, 0, 0, 32'h0001_0000, 0));
    pending_reqs.push_back(mk(0, MX, 0, 0, MN, 0));
    pending_reqs.push_back(mk(5, MN, 7, 5, MX, 7));
    pending_reqs.push_back(mk(0, 1, 0, 0, 0, 0));
    // widest deltas
    pending_reqs.push_back(mk(MN, MN, MN, MX, MX, MX));
    pending_reqs.push_back(mk(MX, MX, MX, MN, MN, MN));
    pending_reqs.push_back(mk(MN, 0, MX, MX, 0, MN));
    // unit deltas on single axes, then deltas on several axes
    pending_reqs.push_back(mk(0, 0, 0, 1, 0, 0));
    pending_reqs.push_back(mk(0, 0, 0, 0, 0, 1));
    pending_reqs.push_back(mk(0, 0, 0, 32'hffff_ffff, 0, 0));
    pending_reqs.push_back(mk(0, 0, 0, 0, 0, 32'hffff_ffff));
    pending_reqs.push_back(mk(0, 0, 0, 1, 1, 1));
    pending_reqs.push_back(mk(1, 1, 1, 0, 0, 0));
    pending_reqs.push_back(mk(0, 0, 0, 1, MX, 0));
    pending_reqs.push_back(mk(0, 0, 0, MX, 1, MX));
    pending_reqs.push_back(mk(MX, 0, 0, MN, 0, 1));
    pending_reqs.push_back(mk(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, MX, MN, MX));

    for (int i = 0; i < 400; i++) begin
      int k;
      k  = $urandom_range(99);
      ex = rnd32(); ey = rnd32(); ez = rnd32();
      if (k < 55)
        pending_reqs.push_back(mk(ex, ey, ez, rnd32(), rnd32(), rnd32()));
      else if (k < 80)
        pending_reqs.push_back(mk(ex, ey, ez, near(ex), near(ey), near(ez)));
      else if (k < 90)
        pending_reqs.push_back(mk(ex, ey, ez, ex, ey, ez));
      else
        pending_reqs.push_back(mk(ex, ey, ez, ex, rnd32(), ez));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_basis.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && stray_results == 0 && expected_basis.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
